// ===== sv/cfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_pkg: shared types, codes and CRC step for the frame parser
// Phase and status codes, the result record and the byte-wise CRC update.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_LEN_LO  = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CRC_LO  = 3'd3,
        PH_CRC_HI  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_BAD = 2'd1,
        ST_BAD_LEN = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_payload;
        t_status    frame_status;
        logic       last;
    } t_result;

    // CRC-16/MCRF4XX, reflected 0x8408, one byte per call
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [7:0]  b;
        logic [15:0] wide_b;
        b      = data ^ crc[7:0];
        b      = b ^ {b[3:0], 4'b0000};
        wide_b = {8'h00, b};
        return ({b, crc[15:8]}) ^ (wide_b >> 4) ^ (wide_b << 3);
    endfunction

endpackage

// ===== sv/cfp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_in_stage: input register
// Holds one received byte until the parser step takes it.
// ----------------------------------------------------------------------------
module cfp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign s_axis_tready = !r_valid || i_take;
    assign o_valid       = r_valid;
    assign o_byte        = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= s_axis_tdata;
        end
    end

endmodule

// ===== sv/cfp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_step: frame phase machine and running CRC
// Consumes one byte per fire, updates state, forms at most one result.
// ----------------------------------------------------------------------------
module cfp_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    output logic               o_res_valid,
    output cfp_pkg::t_result   o_res
);

    cfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_length_low, n_length_low;
    logic [15:0]     r_bytes_left, n_bytes_left;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_rx_crc_low, n_rx_crc_low;

    logic [15:0] w_len;
    logic [15:0] w_rx_crc;
    logic        w_len_bad;

    assign w_len     = {i_byte, r_length_low};
    assign w_rx_crc  = {i_byte, r_rx_crc_low};
    assign w_len_bad = (w_len < 16'd2);

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_length_low = r_length_low;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_rx_crc_low = r_rx_crc_low;
        unique case (r_phase)
            cfp_pkg::PH_LEN_HI: begin
                n_crc = cfp_pkg::CRC_INIT;
                if (w_len_bad) begin
                    n_phase = cfp_pkg::PH_LEN_LO;
                end else begin
                    n_bytes_left = w_len - 16'd2;
                    n_phase      = (w_len == 16'd2) ? cfp_pkg::PH_CRC_LO
                                                    : cfp_pkg::PH_PAYLOAD;
                end
            end
            cfp_pkg::PH_PAYLOAD: begin
                n_crc        = cfp_pkg::crc_update(r_crc, i_byte);
                n_bytes_left = r_bytes_left - 16'd1;
                if (r_bytes_left == 16'd1) begin
                    n_phase = cfp_pkg::PH_CRC_LO;
                end
            end
            cfp_pkg::PH_CRC_LO: begin
                n_rx_crc_low = i_byte;
                n_phase      = cfp_pkg::PH_CRC_HI;
            end
            cfp_pkg::PH_CRC_HI: begin
                n_crc   = cfp_pkg::CRC_INIT;
                n_phase = cfp_pkg::PH_LEN_LO;
            end
            default: begin
                n_length_low = i_byte;
                n_phase      = cfp_pkg::PH_LEN_HI;
            end
        endcase
    end

    // result
    always_comb begin
        o_res_valid        = 1'b0;
        o_res.out_byte     = 8'h00;
        o_res.is_payload   = 1'b0;
        o_res.frame_status = cfp_pkg::ST_OK;
        o_res.last         = 1'b0;
        unique case (r_phase)
            cfp_pkg::PH_LEN_HI: begin
                if (w_len_bad) begin
                    o_res_valid        = 1'b1;
                    o_res.frame_status = cfp_pkg::ST_BAD_LEN;
                    o_res.last         = 1'b1;
                end
            end
            cfp_pkg::PH_PAYLOAD: begin
                o_res_valid      = 1'b1;
                o_res.out_byte   = i_byte;
                o_res.is_payload = 1'b1;
            end
            cfp_pkg::PH_CRC_HI: begin
                o_res_valid        = 1'b1;
                o_res.frame_status = (w_rx_crc == r_crc) ? cfp_pkg::ST_OK
                                                         : cfp_pkg::ST_CRC_BAD;
                o_res.last         = 1'b1;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= cfp_pkg::PH_LEN_LO;
            r_length_low <= 8'h00;
            r_bytes_left <= 16'h0000;
            r_crc        <= cfp_pkg::CRC_INIT;
            r_rx_crc_low <= 8'h00;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_length_low <= n_length_low;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_rx_crc_low <= n_rx_crc_low;
        end
    end

    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.is_payload) |->
            (!o_res.last && o_res.frame_status == cfp_pkg::ST_OK))
        else $error("payload result carries status fields");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.is_payload) |->
            (o_res.last && o_res.out_byte == 8'h00))
        else $error("status result malformed");

    a_payload_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == cfp_pkg::PH_PAYLOAD && r_bytes_left == 16'd1) |=>
            (r_phase == cfp_pkg::PH_CRC_LO))
        else $error("payload count did not end in CRC phase");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_phase) && $stable(r_crc) && $stable(r_bytes_left)))
        else $error("parser state moved without a byte");

endmodule

// ===== sv/cfp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module cfp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_valid,
    input  cfp_pkg::t_result  i_res,
    output logic              o_free,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);

    logic             r_valid;
    cfp_pkg::t_result r_res;

    assign o_free        = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {6'b000000, r_res.frame_status, r_res.out_byte};
    assign m_axis_tuser  = r_res.is_payload;
    assign m_axis_tlast  = r_res.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== sv/crc16_frame_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_frame_parser_top: length-prefixed frame receiver with CRC-16 check
// Parses byte streams of the form length(LE16), payload, CRC-16/MCRF4XX(LE16).
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and sustains one byte per clock while
// the output is not stalled. Each byte passes through an input register, the
// parser logic (phase step plus a byte-wise CRC-16 update) and a result
// register, which loads the byte's result once it is free; the result can
// transfer from there when the output is not stalled. The combinational CRC
// byte update sets the rate. Payload bytes are
// forwarded as they arrive (tuser = 1). The high CRC byte closes the frame
// with a status transfer (tuser = 0, tlast = 1): ok or CRC mismatch. A length
// below two closes at once with a bad-length status. Length and CRC low bytes
// produce no transfer. Input is accepted while a result waits downstream, as
// long as the input register is empty or the result register frees up in the
// same cycle.
// ----------------------------------------------------------------------------
module crc16_frame_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] frame_status
    output logic        m_axis_tuser,   // [0] is_payload
    output logic        m_axis_tlast    // frame close
);

    logic             w_in_valid;
    logic [7:0]       w_in_byte;
    logic             w_out_free;
    logic             w_fire;
    logic             w_res_valid;
    cfp_pkg::t_result w_res;

    // a byte is consumed when the result register can take its outcome
    assign w_fire = w_in_valid && w_out_free;

    cfp_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_take        (w_fire),
        .o_valid       (w_in_valid),
        .o_byte        (w_in_byte)
    );

    cfp_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    cfp_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_fire),
        .i_res_valid   (w_res_valid),
        .i_res         (w_res),
        .o_free        (w_out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for crc16_frame_parser_top
// Feeds byte streams of length-prefixed frames (good and bad CRC, bad
// lengths, empty and long payloads, truncated frames and line noise) with
// random gaps on both stream sides and a long output hold-off. A behavioral
// parser predicts every payload and status transfer in order, and each
// output transfer is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF       = 6;
    localparam int RST_CYCLES     = 8;
    localparam int MAX_GAP        = 11;
    localparam int RANDOM_ITEMS   = 110;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 16;     // margin for the pipeline to empty after the last expected result
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transfer at all

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;      // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;              // [7:0] out_byte, [9:8] frame_status
    logic        m_axis_tuser;              // [0] is_payload
    logic        m_axis_tlast;

    // behavioral parser state
    cfp_pkg::t_phase rx_phase;
    logic [7:0]      rx_len_low;
    logic [15:0]     rx_bytes_left;
    logic [15:0]     rx_crc;
    logic [7:0]      rx_crc_low_byte;

    cfp_pkg::t_result frame_results_q[$];
    logic [7:0]       frame_buf[$];

    int  err_count = 0;
    int  sent_count = 0;
    int  checked_count = 0;
    int  payload_seen = 0;
    int  status_seen[3] = '{0, 0, 0};
    int  stall_cycles = 0;
    int  hold_req = 0;
    bit  s_idle_en = 1'b1;
    bit  m_idle_en = 1'b1;
    bit  rst_done = 1'b0;

    crc16_frame_parser_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // bit-serial CRC-16/MCRF4XX (reflected 0x8408), one byte
    function automatic logic [15:0] mcrf_crc_byte(input logic [15:0] crc,
                                                  input logic [7:0]  data);
        logic [15:0] r;
        r = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
        end
        return r;
    endfunction

    function automatic cfp_pkg::t_result make_result(input logic [7:0] b,
                                                     input logic pl,
                                                     input cfp_pkg::t_status st,
                                                     input logic lst);
        cfp_pkg::t_result r;
        r.out_byte     = b;
        r.is_payload   = pl;
        r.frame_status = st;
        r.last         = lst;
        return r;
    endfunction

    // append one predicted result
    task automatic expect_result(input cfp_pkg::t_result r);
        frame_results_q = {frame_results_q, r};
    endtask

    task automatic reset_parser_model();
        rx_phase        = cfp_pkg::PH_LEN_LO;
        rx_len_low      = 8'h00;
        rx_bytes_left   = 16'h0000;
        rx_crc          = cfp_pkg::CRC_INIT;
        rx_crc_low_byte = 8'h00;
    endtask

    // advance the parser by one accepted byte, queue what it should emit
    task automatic parse_rx_byte(input logic [7:0] b);
        logic [15:0] len;
        logic [15:0] rx_word;
        case (rx_phase)
            cfp_pkg::PH_LEN_HI: begin
                len    = {b, rx_len_low};
                rx_crc = cfp_pkg::CRC_INIT;
                if (len < 16'd2) begin
                    rx_phase = cfp_pkg::PH_LEN_LO;
                    expect_result(make_result(8'h00, 1'b0, cfp_pkg::ST_BAD_LEN, 1'b1));
                end else begin
                    rx_bytes_left = len - 16'd2;
                    rx_phase = (rx_bytes_left == 16'd0) ? cfp_pkg::PH_CRC_LO
                                                        : cfp_pkg::PH_PAYLOAD;
                end
            end
            cfp_pkg::PH_PAYLOAD: begin
                rx_crc        = mcrf_crc_byte(rx_crc, b);
                rx_bytes_left = rx_bytes_left - 16'd1;
                if (rx_bytes_left == 16'd0) rx_phase = cfp_pkg::PH_CRC_LO;
                expect_result(make_result(b, 1'b1, cfp_pkg::ST_OK, 1'b0));
            end
            cfp_pkg::PH_CRC_LO: begin
                rx_crc_low_byte = b;
                rx_phase        = cfp_pkg::PH_CRC_HI;
            end
            cfp_pkg::PH_CRC_HI: begin
                rx_word  = {b, rx_crc_low_byte};
                expect_result(make_result(8'h00, 1'b0,
                    (rx_word == rx_crc) ? cfp_pkg::ST_OK : cfp_pkg::ST_CRC_BAD, 1'b1));
                rx_phase = cfp_pkg::PH_LEN_LO;
                rx_crc   = cfp_pkg::CRC_INIT;
            end
            default: begin
                rx_len_low = b;
                rx_phase   = cfp_pkg::PH_LEN_HI;
            end
        endcase
    endtask

    // one input transfer; tvalid stays up across back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = s_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parse_rx_byte(b);
        sent_count++;
    endtask

    // length, frame_buf as payload, CRC xor'ed with err_mask
    task automatic send_frame(input logic [15:0] err_mask);
        logic [15:0] len;
        logic [15:0] crc;
        len = 16'(frame_buf.size() + 2);
        crc = cfp_pkg::CRC_INIT;
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        foreach (frame_buf[i]) begin
            crc = mcrf_crc_byte(crc, frame_buf[i]);
            send_byte(frame_buf[i]);
        end
        crc = crc ^ err_mask;
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    task automatic fill_random_payload(input int n);
        frame_buf.delete();
        repeat (n) frame_buf = {frame_buf, 8'($urandom)};
    endtask

    // junk that keeps declared lengths short so the parser resyncs quickly
    function automatic logic [7:0] noise_byte();
        case (rx_phase)
            cfp_pkg::PH_LEN_LO: return 8'($urandom_range(0, 24));
            cfp_pkg::PH_LEN_HI: return 8'h00;
            default:            return 8'($urandom);
        endcase
    endfunction

    task automatic resync_parser();
        while (rx_phase != cfp_pkg::PH_LEN_LO) send_byte(noise_byte());
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        err_count++;
        $display("[%0t] MISMATCH %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    // output side: random ready gaps, optional long hold, check each transfer
    initial begin
        int               gap;
        cfp_pkg::t_result want;
        wait (rst_done);
        forever begin
            if (hold_req > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_req) @(posedge i_clk);
                hold_req = 0;
            end
            gap = m_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            checked_count++;
            if (frame_results_q.size() == 0) begin
                report_mismatch("unexpected transfer", m_axis_tdata, 16'h0000);
            end else begin
                want = frame_results_q.pop_front();
                if (want.is_payload) payload_seen++;
                else status_seen[want.frame_status]++;
                if (m_axis_tdata[7:0] != want.out_byte)
                    report_mismatch("out_byte", 16'(m_axis_tdata[7:0]),
                                    16'(want.out_byte));
                if (m_axis_tdata[9:8] != want.frame_status)
                    report_mismatch("frame_status", 16'(m_axis_tdata[9:8]),
                                    16'(want.frame_status));
                if (m_axis_tdata[15:10] != 6'd0)
                    report_mismatch("tdata pad", 16'(m_axis_tdata[15:10]), 16'h0000);
                if (m_axis_tuser != want.is_payload)
                    report_mismatch("is_payload", 16'(m_axis_tuser),
                                    16'(want.is_payload));
                if (m_axis_tlast != want.last)
                    report_mismatch("last", 16'(m_axis_tlast), 16'(want.last));
            end
        end
    end

    // no transfer on either side for too long means the block hung
    always @(posedge i_clk) begin
        if (rst_done) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] timeout: no transfer for %0d cycles, %0d results pending",
                         $realtime, stall_cycles, frame_results_q.size());
                $display("end of test: mismatches");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ---- tests ----

    // corner frames: empty payload, both bad lengths, all-zero/all-one bytes
    task automatic test_directed_frames();
        frame_buf.delete();
        send_frame(16'h0000);                   // empty payload, CRC is init value
        send_frame(16'hFFFF);                   // empty payload, CRC 0000 -> mismatch
        send_byte(8'h00); send_byte(8'h00);     // length zero
        send_byte(8'h01); send_byte(8'h00);     // length one
        frame_buf = '{8'h00};
        send_frame(16'h0000);
        frame_buf = '{8'h00, 8'hFF, 8'hA5};
        send_frame(16'h0000);
        frame_buf = '{8'h5A};
        send_frame(16'h8000);                   // single flipped CRC bit
    endtask

    // length above 255: high length byte in use, every byte value as payload
    task automatic test_long_frame();
        frame_buf.delete();
        for (int i = 0; i < 256; i++) frame_buf = {frame_buf, 8'(i)};
        send_frame(16'h0000);
    endtask

    // output held off while input keeps coming, so the block backs up
    task automatic test_output_backpressure();
        fill_random_payload(40);
        hold_req = HOLD_CYCLES;
        send_frame(16'h0000);
    endtask

    task automatic test_random_traffic();
        int start;
        int kind;
        int n;
        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 15) == 0) begin
                s_idle_en = ($urandom_range(0, 2) != 0);
                m_idle_en = ($urandom_range(0, 2) != 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(0, 12);
                fill_random_payload(n);
                send_frame(($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 16'hFFFF))
                                                       : 16'h0000);
            end else if (kind < 80) begin
                send_byte(8'($urandom_range(0, 1)));
                send_byte(8'h00);
            end else if (kind < 90) begin
                // declared longer than what follows; the next bytes fill it out
                n = $urandom_range(0, 8);
                send_byte(8'(n + 2 + $urandom_range(1, 6)));
                send_byte(8'h00);
                repeat (n) send_byte(8'($urandom));
                resync_parser();
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(noise_byte());
                resync_parser();
            end
        end
        s_idle_en = 1'b1;
        m_idle_en = 1'b1;
    endtask

    initial begin
        reset_parser_model();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        test_directed_frames();
        test_long_frame();
        test_output_backpressure();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input bytes, %0d output transfers checked", sent_count,
                 checked_count);
        $display("payload %0d, status ok %0d / crc mismatch %0d / bad length %0d",
                 payload_seen, status_seen[cfp_pkg::ST_OK],
                 status_seen[cfp_pkg::ST_CRC_BAD], status_seen[cfp_pkg::ST_BAD_LEN]);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", err_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cfp_pkg.sv
sv/cfp_in_stage.sv
sv/cfp_step.sv
sv/cfp_out_stage.sv
sv/crc16_frame_parser_top.sv
dv/tb_top.sv
